>>> sv/sst_pkg.sv
// shared types and constants for the semaphore set table
// no dependencies; imported by every module of the block
`default_nettype none

package sst_pkg;

    // raw command codes on the input port
    localparam logic [2:0] CMD_GET    = 3'd0;
    localparam logic [2:0] CMD_SEMOP  = 3'd1;
    localparam logic [2:0] CMD_GETVAL = 3'd2;
    localparam logic [2:0] CMD_SETVAL = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;

    // command queue between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_GET,
        OP_SEMOP,
        OP_GETVAL,
        OP_SETVAL,
        OP_REMOVE,
        OP_BAD
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERR   = 2'd1,
        ST_BLOCK = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_DISPATCH,
        BS_SCAN,
        BS_ZERO,
        BS_EXEC
    } t_bstate;

    // one classified command beat
    typedef struct packed {
        t_op         op;
        logic [31:0] key;
        logic        create;
        logic [3:0]  size;
        logic [2:0]  sid;
        logic [2:0]  idx;
        logic [31:0] value;
        logic        nowait;
        logic        size_bad;
        logic        sid_bad;
    } t_item;

    // front to queue
    typedef struct packed {
        logic  push;
        t_item item;
    } t_q_in;

    // queue to back
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

endpackage

`default_nettype wire

>>> sv/sst_front.sv
// front end: accepts command beats and classifies them
// depends on sst_pkg
`default_nettype none

module sst_front import sst_pkg::*; #(
    parameter int NUM_SETS     = 8,
    parameter int SEMS_PER_SET = 8
) (
    input  wire                logic        start,
    input  wire                logic        i_full,
    input  wire                logic [2:0]  i_command,
    input  wire                logic [31:0] i_key,
    input  wire                logic        i_create_flag,
    input  wire                logic [3:0]  i_set_size,
    input  wire                logic [2:0]  i_set_id,
    input  wire                logic [2:0]  i_sem_index,
    input  wire                logic [31:0] i_value,
    input  wire                logic        i_nowait_flag,
    output t_q_in                           o_q_in
);

    t_op w_op;

    // decode the command code
    always_comb begin
        case (i_command)
            CMD_GET:    w_op = OP_GET;
            CMD_SEMOP:  w_op = OP_SEMOP;
            CMD_GETVAL: w_op = OP_GETVAL;
            CMD_SETVAL: w_op = OP_SETVAL;
            CMD_REMOVE: w_op = OP_REMOVE;
            default:    w_op = OP_BAD;
        endcase
    end

    // build the queue entry with range checks done up front
    always_comb begin
        o_q_in.push          = start && !i_full;
        o_q_in.item.op       = w_op;
        o_q_in.item.key      = i_key;
        o_q_in.item.create   = i_create_flag;
        o_q_in.item.size     = i_set_size;
        o_q_in.item.sid      = i_set_id;
        o_q_in.item.idx      = i_sem_index;
        o_q_in.item.value    = i_value;
        o_q_in.item.nowait   = i_nowait_flag;
        o_q_in.item.size_bad = (i_set_size == 4'd0) || (int'(i_set_size) > SEMS_PER_SET);
        o_q_in.item.sid_bad  = int'(i_set_id) >= NUM_SETS;
    end

endmodule

`default_nettype wire

>>> sv/sst_queue.sv
// short command queue between front and back
// depends on sst_pkg
`default_nettype none

module sst_queue import sst_pkg::*; (
    input  wire   logic i_clk,
    input  wire   logic i_rst_n,
    input  wire   t_q_in i_q_in,
    input  wire   logic i_pop,
    output logic        o_full,
    output t_q_out      o_q_out
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_item          r_mem [Q_DEPTH];
    logic [PW-1:0]  r_head;
    logic [PW-1:0]  r_tail;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_head;
    logic [PW-1:0]  n_tail;
    logic           w_pop;

    assign o_full        = r_count == CW'(Q_DEPTH);
    assign o_q_out.valid = r_count != '0;
    assign o_q_out.item  = r_mem[r_head];
    assign w_pop         = i_pop && o_q_out.valid;

    // pointer wrap
    always_comb begin
        n_head = (r_head == PW'(Q_DEPTH - 1)) ? '0 : PW'(r_head + 1'b1);
        n_tail = (r_tail == PW'(Q_DEPTH - 1)) ? '0 : PW'(r_tail + 1'b1);
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_q_in.push) r_tail <= n_tail;
            if (w_pop)       r_head <= n_head;
            if (i_q_in.push && !w_pop)      r_count <= CW'(r_count + 1'b1);
            else if (!i_q_in.push && w_pop) r_count <= CW'(r_count - 1'b1);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_q_in.push) r_mem[r_tail] <= i_q_in.item;
    end

endmodule

`default_nettype wire

>>> sv/sst_back.sv
// back end: set table, counter memory and command sequencer
// depends on sst_pkg
`default_nettype none

module sst_back import sst_pkg::*; #(
    parameter int NUM_SETS     = 8,
    parameter int SEMS_PER_SET = 8
) (
    input  wire    logic        i_clk,
    input  wire    logic        i_rst_n,
    input  wire    t_q_out      i_q_out,
    output logic                o_pop,
    output logic                o_strobe,
    output logic [1:0]          o_status,
    output logic [30:0]         o_result_value
);

    localparam int DEPTH = NUM_SETS * SEMS_PER_SET;
    localparam int IW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int ZW    = (SEMS_PER_SET > 1) ? $clog2(SEMS_PER_SET) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // set table and counter memory
    logic          r_in_use [NUM_SETS];
    logic [31:0]   r_key    [NUM_SETS];
    logic [3:0]    r_size   [NUM_SETS];
    logic [30:0]   r_cnt_mem [DEPTH];
    logic [30:0]   r_rdata;

    // sequencer
    t_bstate       r_state, n_state;
    t_item         r_item;
    logic [IW-1:0] r_scan, n_scan;
    logic          r_free_found, n_free_found;
    logic [IW-1:0] r_free_id, n_free_id;
    logic [IW-1:0] r_claim_id, n_claim_id;
    logic [ZW-1:0] r_zcnt, n_zcnt;
    logic          r_strobe, n_strobe;
    t_status       r_status, n_status;
    logic [30:0]   r_value, n_value;

    // table and memory controls
    logic          w_claim_en;
    logic          w_rm_en;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [30:0]   w_wr_data;
    logic [AW-1:0] w_rd_addr;

    // operand views
    logic [IW-1:0] w_sid_ix;
    logic [ZW-1:0] w_idx_ix;
    logic          w_set_ok;
    logic          w_idx_bad;
    logic          w_scan_hit;
    logic          w_scan_free;
    logic          w_scan_last;
    logic [31:0]   w_mag;
    logic          w_p_ok;
    logic [30:0]   w_p_new;
    logic [31:0]   w_sum;
    logic          w_zero_last;

    assign o_pop          = (r_state == BS_IDLE) && i_q_out.valid;
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_result_value = r_value;

    // address and check terms
    always_comb begin
        w_sid_ix    = IW'(r_item.sid);
        w_idx_ix    = ZW'(r_item.idx);
        w_set_ok    = !r_item.sid_bad && r_in_use[w_sid_ix];
        w_idx_bad   = (8'(r_item.idx) >= 8'(r_size[w_sid_ix]))
                      || (int'(r_item.idx) >= SEMS_PER_SET);
        w_rd_addr   = AW'(AW'(w_sid_ix) * AW'(SEMS_PER_SET) + AW'(w_idx_ix));
        w_scan_hit  = (r_item.key != 32'd0) && r_in_use[r_scan] && (r_key[r_scan] == r_item.key);
        w_scan_free = !r_in_use[r_scan];
        w_scan_last = r_scan == IW'(NUM_SETS - 1);
        w_zero_last = int'(r_zcnt) == (int'(r_item.size) - 1);
    end

    // semaphore arithmetic on the fetched counter
    always_comb begin
        w_mag   = ~r_item.value + 32'd1;
        w_p_ok  = {1'b0, r_rdata} >= w_mag;
        w_p_new = r_rdata - w_mag[30:0];
        w_sum   = {1'b0, r_rdata} + {1'b0, r_item.value[30:0]};
    end

    // next state and outputs
    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_free_found = r_free_found;
        n_free_id    = r_free_id;
        n_claim_id   = r_claim_id;
        n_zcnt       = r_zcnt;
        n_strobe     = 1'b0;
        n_status     = ST_OK;
        n_value      = '0;
        w_claim_en   = 1'b0;
        w_rm_en      = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_addr    = w_rd_addr;
        w_wr_data    = '0;

        case (r_state)
            BS_IDLE: begin
                if (i_q_out.valid) n_state = BS_DISPATCH;
            end

            BS_DISPATCH: begin
                n_state = BS_IDLE;
                if (r_item.op == OP_BAD) begin
                    n_strobe = 1'b1;
                    n_status = ST_ERR;
                end else if (r_item.op == OP_GET) begin
                    if (r_item.size_bad) begin
                        n_strobe = 1'b1;
                        n_status = ST_ERR;
                    end else begin
                        n_scan       = '0;
                        n_free_found = 1'b0;
                        n_state      = BS_SCAN;
                    end
                end else if (!w_set_ok) begin
                    n_strobe = 1'b1;
                    n_status = ST_ERR;
                end else if (r_item.op == OP_REMOVE) begin
                    w_rm_en  = 1'b1;
                    n_strobe = 1'b1;
                end else if (w_idx_bad) begin
                    n_strobe = 1'b1;
                    n_status = ST_ERR;
                end else if (r_item.op == OP_SETVAL) begin
                    n_strobe = 1'b1;
                    if (r_item.value[31]) begin
                        n_status = ST_ERR;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_data = r_item.value[30:0];
                    end
                end else begin
                    // getval or op: counter arrives next cycle
                    n_state = BS_EXEC;
                end
            end

            BS_SCAN: begin
                if (w_scan_free && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_id    = r_scan;
                end
                if (w_scan_hit) begin
                    n_strobe = 1'b1;
                    n_value  = 31'(r_scan);
                    n_state  = BS_IDLE;
                end else if (w_scan_last) begin
                    n_strobe = 1'b1;
                    n_state  = BS_IDLE;
                    if ((r_item.key != 32'd0) && !r_item.create) begin
                        n_status = ST_ERR;
                    end else if (r_free_found || w_scan_free) begin
                        // claim the lowest free set, then clear its counters
                        w_claim_en = 1'b1;
                        n_claim_id = r_free_found ? r_free_id : r_scan;
                        n_value    = 31'(n_claim_id);
                        n_zcnt     = '0;
                        n_state    = BS_ZERO;
                    end else begin
                        n_status = ST_ERR;
                    end
                end else begin
                    n_scan = IW'(r_scan + 1'b1);
                end
            end

            BS_ZERO: begin
                w_wr_en   = 1'b1;
                w_wr_addr = AW'(AW'(r_claim_id) * AW'(SEMS_PER_SET) + AW'(r_zcnt));
                w_wr_data = '0;
                n_zcnt    = ZW'(r_zcnt + 1'b1);
                if (w_zero_last) n_state = BS_IDLE;
            end

            BS_EXEC: begin
                n_state  = BS_IDLE;
                n_strobe = 1'b1;
                if (r_item.op == OP_GETVAL) begin
                    n_value = r_rdata;
                end else if (r_item.value[31]) begin
                    if (w_p_ok) begin
                        w_wr_en   = 1'b1;
                        w_wr_data = w_p_new;
                    end else begin
                        n_status = r_item.nowait ? ST_ERR : ST_BLOCK;
                    end
                end else if (r_item.value != 32'd0) begin
                    if (!w_sum[31]) begin
                        w_wr_en   = 1'b1;
                        w_wr_data = w_sum[30:0];
                    end else begin
                        n_status = ST_ERR;
                    end
                end else if (r_rdata != 31'd0) begin
                    n_status = r_item.nowait ? ST_ERR : ST_BLOCK;
                end
            end

            default: n_state = BS_IDLE;
        endcase
    end

    // state register and control flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // sequencer payload
    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_q_out.item;
        r_scan       <= n_scan;
        r_free_found <= n_free_found;
        r_free_id    <= n_free_id;
        r_claim_id   <= n_claim_id;
        r_zcnt       <= n_zcnt;
        r_status     <= n_status;
        r_value      <= n_value;
    end

    // in-use bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SETS; i++) r_in_use[i] <= 1'b0;
        end else begin
            if (w_claim_en) r_in_use[n_claim_id] <= 1'b1;
            if (w_rm_en)    r_in_use[w_sid_ix]   <= 1'b0;
        end
    end

    // key and size of a claimed set
    always_ff @(posedge i_clk) begin
        if (w_claim_en) begin
            r_key[n_claim_id]  <= r_item.key;
            r_size[n_claim_id] <= r_item.size;
        end
    end

    // counter memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_cnt_mem[w_wr_addr] <= w_wr_data;
        r_rdata <= r_cnt_mem[w_rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/semaphore_set_table.sv
// semaphore set table top level: front, command queue and back
// a beat is queued, popped when the back is idle and dispatched: errors, remove and setval
// answer from dispatch, getval and op from exec after the registered counter read, a get
// from the scan of set slots, ending on a key hit or the last slot; a claim then clears size
// counters before the next beat; the back takes one beat at a time, two can wait in the queue
// reset clears in-use bits, queue and sequencer at once; results cannot be held off
`default_nettype none

module semaphore_set_table import sst_pkg::*; #(
    parameter int NUM_SETS     = 8,
    parameter int SEMS_PER_SET = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_command,
    input  wire logic signed [31:0] i_key,
    input  wire logic               i_create_flag,
    input  wire logic [3:0]         i_set_size,
    input  wire logic [2:0]         i_set_id,
    input  wire logic [2:0]         i_sem_index,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_nowait_flag,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic [30:0]             o_result_value
);

    t_q_in  w_q_in;
    t_q_out w_q_out;
    logic   w_full;
    logic   w_pop;

    assign busy = w_full;

    // classify incoming beats
    sst_front #(
        .NUM_SETS     (NUM_SETS),
        .SEMS_PER_SET (SEMS_PER_SET)
    ) u_front (
        .start         (start),
        .i_full        (w_full),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_create_flag (i_create_flag),
        .i_set_size    (i_set_size),
        .i_set_id      (i_set_id),
        .i_sem_index   (i_sem_index),
        .i_value       (i_value),
        .i_nowait_flag (i_nowait_flag),
        .o_q_in        (w_q_in)
    );

    // decoupling queue
    sst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_in  (w_q_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_q_out (w_q_out)
    );

    // execute against the table
    sst_back #(
        .NUM_SETS     (NUM_SETS),
        .SEMS_PER_SET (SEMS_PER_SET)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_out        (w_q_out),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_result_value (o_result_value)
    );

    // an accepted beat is waiting in the queue on the next cycle
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> w_q_out.valid)
        else $error("accepted beat not queued");

    // results are never back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

    // error and would-block answers carry a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_OK)) |-> (o_result_value == 31'd0))
        else $error("non-zero value on a failed result");

    // the back takes one beat and dispatches it before the next pop
    a_pop_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> !w_pop)
        else $error("pop while the back is busy");

endmodule

`default_nettype wire

>>> test/sst_tb_pkg.sv
`timescale 1ns / 1ps
// answer book for the semaphore set table bench: command beat and answer types
// plus a class that predicts each answer and checks the ones the block returns
// depends on sst_pkg for command codes and status values

package sst_tb_pkg;
    import sst_pkg::*;

    localparam int SET_COUNT        = 8;
    localparam int COUNTERS_PER_SET = 8;
    // lowest command code the block does not know
    localparam logic [2:0] CMD_FIRST_UNKNOWN = 3'd5;

    // one command beat as driven on the ports
    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] key;
        logic        create;
        logic [3:0]  size;
        logic [2:0]  sid;
        logic [2:0]  idx;
        logic [31:0] value;
        logic        nowait;
    } t_beat;

    // one answer from the block
    typedef struct packed {
        t_status     status;
        logic [30:0] value;
    } t_answer;

    class sst_answer_book;
        bit          set_used[SET_COUNT];
        logic [31:0] key_of[SET_COUNT];
        logic [3:0]  size_of[SET_COUNT];
        logic [30:0] count_of[SET_COUNT * COUNTERS_PER_SET];
        t_answer     answer_q[$];
        int          fails;
        int          beats_by_cmd[8];
        int          answers_by_status[3];

        function int used_count();
            int n;
            n = 0;
            foreach (set_used[i]) n += set_used[i];
            return n;
        endfunction

        function logic [2:0] random_used_set();
            int unsigned pool[$];
            foreach (set_used[i]) if (set_used[i]) pool.push_back(i);
            if (pool.size() == 0) return 3'($urandom_range(0, SET_COUNT - 1));
            return 3'(pool[$urandom_range(0, pool.size() - 1)]);
        endfunction

        // predict the answer to an accepted command and update the table copy
        function void note_command(t_beat b);
            t_answer     a;
            logic [5:0]  slot;
            logic [30:0] cur;
            logic [32:0] wide;
            bit          hit;
            a.status = ST_ERR;
            a.value  = '0;
            hit      = 0;
            beats_by_cmd[b.cmd]++;
            if (b.cmd == CMD_GET) begin
                if (b.size != 0 && b.size <= COUNTERS_PER_SET) begin
                    // a non-private key looks for a live set first
                    if (b.key != 0) begin
                        for (int i = 0; i < SET_COUNT; i++) begin
                            if (!hit && set_used[i] && key_of[i] == b.key) begin
                                hit      = 1;
                                a.status = ST_OK;
                                a.value  = 31'(i);
                            end
                        end
                    end
                    // claim the lowest free set and clear its counters
                    if (!hit && (b.key == 0 || b.create)) begin
                        for (int i = 0; i < SET_COUNT; i++) begin
                            if (!hit && !set_used[i]) begin
                                hit         = 1;
                                set_used[i] = 1;
                                key_of[i]   = b.key;
                                size_of[i]  = b.size;
                                for (int j = 0; j < b.size; j++)
                                    count_of[i * COUNTERS_PER_SET + j] = '0;
                                a.status = ST_OK;
                                a.value  = 31'(i);
                            end
                        end
                    end
                end
            end else if (b.cmd <= CMD_REMOVE && set_used[b.sid]) begin
                if (b.cmd == CMD_REMOVE) begin
                    set_used[b.sid] = 0;
                    a.status        = ST_OK;
                end else if ({1'b0, b.idx} < size_of[b.sid]) begin
                    slot = {b.sid, b.idx};
                    cur  = count_of[slot];
                    case (b.cmd)
                        CMD_GETVAL: begin
                            a.status = ST_OK;
                            a.value  = cur;
                        end
                        CMD_SETVAL: begin
                            if (!b.value[31]) begin
                                count_of[slot] = b.value[30:0];
                                a.status       = ST_OK;
                            end
                        end
                        default: begin
                            if (b.value[31]) begin
                                // P: needs the counter to cover the magnitude
                                wide = 33'h1_0000_0000 - {1'b0, b.value};
                                if ({2'b00, cur} < wide) begin
                                    a.status = b.nowait ? ST_ERR : ST_BLOCK;
                                end else begin
                                    count_of[slot] = cur - wide[30:0];
                                    a.status       = ST_OK;
                                end
                            end else if (b.value != 0) begin
                                // V: sum must stay within 31 bits
                                wide = {2'b00, cur} + {1'b0, b.value};
                                if (wide <= 33'h0_7FFF_FFFF) begin
                                    count_of[slot] = wide[30:0];
                                    a.status       = ST_OK;
                                end
                            end else if (cur != 0) begin
                                a.status = b.nowait ? ST_ERR : ST_BLOCK;
                            end else begin
                                a.status = ST_OK;
                            end
                        end
                    endcase
                end
            end
            answers_by_status[a.status]++;
            answer_q.push_back(a);
        endfunction

        // compare one strobed answer with the oldest prediction
        function void check_answer(logic [1:0] status, logic [30:0] value);
            t_answer want;
            if (answer_q.size() == 0) begin
                $error("unexpected answer: status %0d, result_value %0d", status, value);
                fails++;
            end else begin
                want = answer_q.pop_front();
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fails++;
                end
                if (value !== want.value) begin
                    $error("result_value: expected %0d, got %0d", want.value, value);
                    fails++;
                end
            end
        endfunction
    endclass

endpackage

>>> test/tb.sv
`timescale 1ns / 1ps
// top-level bench for semaphore_set_table: directed and random command beats
// with random sender gaps, every answer checked against sst_tb_pkg's answer book
// depends on sst_pkg, sst_tb_pkg and the semaphore_set_table rtl

module tb;
    import sst_pkg::*;
    import sst_tb_pkg::*;

    localparam int RANDOM_BEATS = 1050;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_command;
    logic signed [31:0] i_key;
    logic               i_create_flag;
    logic [3:0]         i_set_size;
    logic [2:0]         i_set_id;
    logic [2:0]         i_sem_index;
    logic signed [31:0] i_value;
    logic               i_nowait_flag;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [30:0]        o_result_value;

    sst_answer_book sb;

    semaphore_set_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_create_flag  (i_create_flag),
        .i_set_size     (i_set_size),
        .i_set_id       (i_set_id),
        .i_sem_index    (i_sem_index),
        .i_value        (i_value),
        .i_nowait_flag  (i_nowait_flag),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_result_value (o_result_value)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // answer monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_answer(o_status, o_result_value);
    end

    // overall time limit
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_beat mk(logic [2:0] cmd, logic [31:0] key, logic create,
                                 logic [3:0] size, logic [2:0] sid, logic [2:0] idx,
                                 logic [31:0] value, logic nowait);
        t_beat b;
        b.cmd    = cmd;
        b.key    = key;
        b.create = create;
        b.size   = size;
        b.sid    = sid;
        b.idx    = idx;
        b.value  = value;
        b.nowait = nowait;
        return b;
    endfunction

    // keys from a small pool so lookups hit, with private and wild keys mixed in
    function automatic logic [31:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 32'd0;
        if (r < 75) begin
            case ($urandom_range(0, 5))
                0: return 32'd1;
                1: return 32'd2;
                2: return 32'd3;
                3: return 32'hFFFF_FFFF;
                4: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom();
    endfunction

    // mostly well-formed commands on live sets, with noise on top
    function automatic t_beat random_beat();
        t_beat       b;
        int unsigned r;
        int unsigned used;
        b.key    = $urandom();
        b.create = 1'($urandom_range(0, 1));
        b.size   = 4'($urandom_range(0, 15));
        b.sid    = 3'($urandom_range(0, 7));
        b.idx    = 3'($urandom_range(0, 7));
        b.value  = $urandom();
        b.nowait = 1'($urandom_range(0, 1));
        used     = sb.used_count();
        r        = $urandom_range(0, 99);
        if (used == 0 && r < 70) r = 0;
        if (r < 20) begin
            b.cmd    = CMD_GET;
            b.key    = pick_key();
            b.create = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) != 0) b.size = 4'($urandom_range(1, COUNTERS_PER_SET));
        end else begin
            if (r < 55)      b.cmd = CMD_SEMOP;
            else if (r < 68) b.cmd = CMD_GETVAL;
            else if (r < 80) b.cmd = CMD_SETVAL;
            else if (r < 95) b.cmd = CMD_REMOVE;
            else             b.cmd = 3'($urandom_range(CMD_FIRST_UNKNOWN, 7));
            if (used != 0 && $urandom_range(0, 9) != 0) b.sid = sb.random_used_set();
            if (sb.set_used[b.sid] && $urandom_range(0, 9) != 0)
                b.idx = 3'($urandom_range(0, int'(sb.size_of[b.sid]) - 1));
            r = $urandom_range(0, 99);
            if (b.cmd == CMD_SEMOP) begin
                if (r < 40)      b.value = -32'($urandom_range(1, 3));
                else if (r < 70) b.value = 32'($urandom_range(1, 3));
                else if (r < 82) b.value = 32'd0;
                else if (r < 88) b.value = 32'h8000_0000;
                else if (r < 92) b.value = 32'h7FFF_FFFF;
            end else if (b.cmd == CMD_SETVAL) begin
                if (r < 60)      b.value = 32'($urandom_range(0, 5));
                else if (r < 80) b.value = 32'h7FFF_FFFF - 32'($urandom_range(0, 15));
            end
        end
        return b;
    endfunction

    // sender gap in cycles: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // drive one beat, wait for it to be taken, then idle for the given gap
    task automatic send_beat(input t_beat b, input int unsigned gap);
        @(negedge i_clk);
        i_command     = b.cmd;
        i_key         = b.key;
        i_create_flag = b.create;
        i_set_size    = b.size;
        i_set_id      = b.sid;
        i_sem_index   = b.idx;
        i_value       = b.value;
        i_nowait_flag = b.nowait;
        start         = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_command(b);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    initial begin
        t_beat directed_q[$];
        int    waited;
        bit    burst;
        sb            = new();
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_command     = CMD_GET;
        i_key         = '0;
        i_create_flag = 1'b0;
        i_set_size    = '0;
        i_set_id      = '0;
        i_sem_index   = '0;
        i_value       = '0;
        i_nowait_flag = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: size checks, key lookup, private key, counter edge cases
        directed_q.push_back(mk(CMD_GET,    32'd5,        1, 4'd0, 0, 0, 0, 0));
        directed_q.push_back(mk(CMD_GET,    32'd0,        0, 4'd8, 0, 0, 0, 0));
        directed_q.push_back(mk(CMD_GET,    32'h8000_0000, 1, 4'd1, 0, 0, 0, 0));
        directed_q.push_back(mk(CMD_GET,    32'h8000_0000, 0, 4'd3, 0, 0, 0, 0));
        directed_q.push_back(mk(CMD_GET,    32'h7FFF_FFFF, 0, 4'd1, 0, 0, 0, 0));
        directed_q.push_back(mk(CMD_GET,    32'h7FFF_FFFF, 1, 4'd8, 0, 0, 0, 0));
        directed_q.push_back(mk(CMD_GET,    32'h8000_0000, 1, 4'd9, 0, 0, 0, 0));
        directed_q.push_back(mk(CMD_SETVAL, 0, 0, 0, 3'd0, 3'd7, 32'h7FFF_FFFF, 0));
        directed_q.push_back(mk(CMD_SEMOP,  0, 0, 0, 3'd0, 3'd7, 32'd1, 0));
        directed_q.push_back(mk(CMD_GETVAL, 0, 0, 0, 3'd0, 3'd7, 0, 0));
        directed_q.push_back(mk(CMD_SEMOP,  0, 0, 0, 3'd0, 3'd7, 32'h8000_0000, 0));
        directed_q.push_back(mk(CMD_SEMOP,  0, 0, 0, 3'd0, 3'd7, 32'hFFFF_FFFF, 1));
        directed_q.push_back(mk(CMD_SEMOP,  0, 0, 0, 3'd0, 3'd7, 32'd0, 1));
        directed_q.push_back(mk(CMD_SEMOP,  0, 0, 0, 3'd0, 3'd0, 32'hFFFF_FFFF, 0));
        directed_q.push_back(mk(CMD_SETVAL, 0, 0, 0, 3'd0, 3'd3, 32'hFFFF_FFFF, 0));
        directed_q.push_back(mk(CMD_GETVAL, 0, 0, 0, 3'd1, 3'd1, 0, 0));
        directed_q.push_back(mk(CMD_GETVAL, 0, 0, 0, 3'd5, 3'd0, 0, 0));
        directed_q.push_back(mk(CMD_REMOVE, 0, 0, 0, 3'd1, 3'd0, 0, 0));
        directed_q.push_back(mk(3'd7,       0, 0, 0, 0, 0, 0, 0));
        // fill the table with private sets, then one claim too many
        for (int i = 0; i < 7; i++)
            directed_q.push_back(mk(CMD_GET, 32'd0, 0, 4'(1 + i), 0, 0, 0, 0));
        foreach (directed_q[i]) send_beat(directed_q[i], pick_gap());

        // random: each stretch of 64 beats is a burst with no sender gaps or a gapped stretch
        burst = 0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 64 == 0) burst = ($urandom_range(0, 2) == 0);
            send_beat(random_beat(), burst ? 0 : pick_gap());
        end

        // drain
        @(negedge i_clk);
        start  = 1'b0;
        waited = 0;
        while (sb.answer_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (30) @(posedge i_clk);
        if (sb.answer_q.size() != 0) begin
            $error("%0d answers never arrived", sb.answer_q.size());
            sb.fails++;
        end

        $display("ran %0d get, %0d op, %0d getval, %0d setval, %0d remove, %0d unknown commands",
                 sb.beats_by_cmd[CMD_GET], sb.beats_by_cmd[CMD_SEMOP],
                 sb.beats_by_cmd[CMD_GETVAL], sb.beats_by_cmd[CMD_SETVAL],
                 sb.beats_by_cmd[CMD_REMOVE],
                 sb.beats_by_cmd[5] + sb.beats_by_cmd[6] + sb.beats_by_cmd[7]);
        $display("answers predicted: %0d ok, %0d error, %0d would-block",
                 sb.answers_by_status[ST_OK], sb.answers_by_status[ST_ERR],
                 sb.answers_by_status[ST_BLOCK]);
        if (sb.fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
sv/sst_pkg.sv
sv/sst_front.sv
sv/sst_queue.sv
sv/sst_back.sv
sv/semaphore_set_table.sv
test/sst_tb_pkg.sv
test/tb.sv
